// ----- hdl/rmse_pkg.sv -----
// Shared types, codes and constants for the RTP-MIDI session initiator.
// Used by every module of the block; no dependencies of its own.
package rmse_pkg;

	// Input command codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_PKT  = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_PEER_IP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CTRL_PORT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_INT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ATT_LIMIT  = 3'd4;
	localparam int CFG_DATA_W = 32;

	// Packet header checks and command words
	localparam logic [15:0] MAGIC_WORD  = 16'hFFFF;
	localparam logic [8:0]  MIN_HDR_LEN = 9'd4;
	localparam logic [8:0]  CK_LEN      = 9'd36;
	localparam logic [15:0] WORD_OK     = 16'h4F4B;
	localparam logic [15:0] WORD_NO     = 16'h4E4F;
	localparam logic [15:0] WORD_BY     = 16'h4259;
	localparam logic [15:0] WORD_CK     = 16'h434B;

	// Round trip in ticks saturates once it reaches 65536 ms
	localparam logic [19:0] RTT_SAT_TICKS = 20'd655360;
	// ceil(2^23 / 10): exact quotient by ten for operands below 2^22
	localparam logic [22:0] DIV10_RECIP   = 23'd838861;
	localparam logic [15:0] RTT_MAX       = 16'hFFFF;

	// Clock-sync count bytes sent
	localparam logic [1:0] CK_COUNT_0 = 2'd0;
	localparam logic [1:0] CK_COUNT_1 = 2'd1;
	localparam logic [1:0] CK_COUNT_2 = 2'd2;

	typedef enum logic [2:0] {
		PH_OFFLINE  = 3'd0,
		PH_CTRL_INV = 3'd1,
		PH_DATA_INV = 3'd3,
		PH_DATA_ACC = 3'd4,
		PH_SYNCED   = 3'd5,
		PH_STOPPED  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		SK_NONE   = 2'd0,
		SK_INVITE = 2'd1,
		SK_SYNC   = 2'd2,
		SK_END    = 2'd3
	} kind_t;

	// What one item does to the session
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_INV_NEW,
		ACT_INV_CTRL_RE,
		ACT_INV_DATA_RE,
		ACT_SYNC_TICK,
		ACT_OK_CTRL,
		ACT_OK_DATA,
		ACT_NOBY,
		ACT_CK0,
		ACT_CK1,
		ACT_STOP
	} act_t;

	typedef struct packed {
		logic [31:0] peer_ip;
		logic [15:0] ctrl_port;
		logic [19:0] retry_interval;
		logic [23:0] sync_interval;
		logic [7:0]  attempt_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        on_data_port;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [8:0]  pkt_len;
		logic [15:0] magic;
		logic [15:0] cmd_word;
		logic [7:0]  sync_count;
		logic [63:0] sync_t1;
		logic [63:0] sync_t2;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic        via_data;
		logic [31:0] ip;
		logic [15:0] port;
		logic [1:0]  count;
		logic [63:0] ts1;
		logic [63:0] ts2;
		logic [63:0] ts3;
		phase_t      phase;
		logic [15:0] latency;
		logic        last;
	} res_t;

endpackage

// ----- hdl/rmse_cfg.sv -----
// Configuration registers of the session initiator, written through a plain write port.
// Depends on rmse_pkg.
module rmse_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [rmse_pkg::CFG_IDX_W-1:0]  idx,
	input  logic [rmse_pkg::CFG_DATA_W-1:0] wdata,
	output rmse_pkg::cfg_t                  cfg
);
	import rmse_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peer_ip        <= 32'd0;
			cfg_q.ctrl_port      <= 16'd5004;
			cfg_q.retry_interval <= 20'd15000;
			cfg_q.sync_interval  <= 24'd100000;
			cfg_q.attempt_limit  <= 8'd20;
		end else if (we) begin
			unique case (idx)
				CFG_PEER_IP:   cfg_q.peer_ip        <= wdata;
				CFG_CTRL_PORT: cfg_q.ctrl_port      <= wdata[15:0];
				CFG_RETRY_INT: cfg_q.retry_interval <= wdata[19:0];
				CFG_SYNC_INT:  cfg_q.sync_interval  <= wdata[23:0];
				CFG_ATT_LIMIT: cfg_q.attempt_limit  <= wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/rmse_core.sv -----
// Session state and per-item decision logic: phase, peers, timers, latency.
// Depends on rmse_pkg; driven by the input register of the top level.
module rmse_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  rmse_pkg::item_t item,
	input  rmse_pkg::cfg_t  cfg,
	output rmse_pkg::res_t  res0,
	output rmse_pkg::res_t  res1,
	output logic            two
);
	import rmse_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  attempts_q, attempts_d;
	logic [63:0] now_q, now_d;
	logic [63:0] last_send_q, last_send_d;
	logic        learned_q, learned_d;
	logic [31:0] ctrl_ip_q, ctrl_ip_d;
	logic [15:0] ctrl_port_q, ctrl_port_d;
	logic [31:0] data_ip_q, data_ip_d;
	logic [15:0] data_port_q, data_port_d;
	logic [15:0] rtt_q, rtt_d;

	act_t        act;
	logic [63:0] now_inc;
	logic [63:0] gap;
	logic        retry_due, sync_due;
	logic [31:0] cp_ip;
	logic [15:0] cp_port;
	logic [15:0] data_port_next;
	logic        pkt_ok, ck_ok;
	logic [63:0] rtt_diff;
	logic        rtt_sat;
	logic [42:0] rtt_prod;
	logic [15:0] rtt_new;

	// Control peer: learned address, else configured one
	assign cp_ip          = learned_q ? ctrl_ip_q : cfg.peer_ip;
	assign cp_port        = learned_q ? ctrl_port_q : cfg.ctrl_port;
	assign data_port_next = cfg.ctrl_port + 16'd1;

	// Tick timing against the last send stamp
	assign now_inc   = now_q + 64'd1;
	assign gap       = now_inc - last_send_q;
	assign retry_due = gap > {44'd0, cfg.retry_interval};
	assign sync_due  = gap > {40'd0, cfg.sync_interval};

	// Header checks
	assign pkt_ok = (phase_q != PH_STOPPED) && (item.pkt_len >= MIN_HDR_LEN)
		&& (item.magic == MAGIC_WORD);
	assign ck_ok  = (item.cmd_word == WORD_CK) && (item.pkt_len >= CK_LEN);

	// Round trip in ms: divide by ten through a reciprocal, saturate when large
	assign rtt_diff = now_q - item.sync_t1;
	assign rtt_sat  = (rtt_diff[63:20] != 44'd0) || (rtt_diff[19:0] >= RTT_SAT_TICKS);
	assign rtt_prod = {23'd0, rtt_diff[19:0]} * {20'd0, DIV10_RECIP};
	assign rtt_new  = rtt_sat ? RTT_MAX : rtt_prod[38:23];

	// Classify the item
	always_comb begin
		act = ACT_NONE;
		priority if (item.cmd == CMD_TICK) begin
			unique case (phase_q)
				PH_OFFLINE:  if (attempts_q < cfg.attempt_limit) act = ACT_INV_NEW;
				PH_CTRL_INV: if (retry_due) act = ACT_INV_CTRL_RE;
				PH_DATA_INV: if (retry_due) act = ACT_INV_DATA_RE;
				PH_DATA_ACC,
				PH_SYNCED:   if (sync_due) act = ACT_SYNC_TICK;
				default:     act = ACT_NONE;
			endcase
		end else if (item.cmd == CMD_PKT) begin
			if (pkt_ok) begin
				priority if (item.cmd_word == WORD_OK)
					act = item.on_data_port ? ACT_OK_DATA : ACT_OK_CTRL;
				else if (item.cmd_word == WORD_NO || item.cmd_word == WORD_BY)
					act = ACT_NOBY;
				else if (ck_ok && item.sync_count == 8'd0)
					act = ACT_CK0;
				else if (ck_ok && item.sync_count == 8'd1)
					act = ACT_CK1;
				else
					act = ACT_NONE;
			end
		end else if (item.cmd == CMD_STOP) begin
			if (phase_q != PH_STOPPED) act = ACT_STOP;
		end else begin
			// Drop an unknown command
			act = ACT_NONE;
		end
	end

	// Next state
	always_comb begin
		phase_d     = phase_q;
		attempts_d  = attempts_q;
		now_d       = (item.cmd == CMD_TICK) ? now_inc : now_q;
		last_send_d = last_send_q;
		learned_d   = learned_q;
		ctrl_ip_d   = ctrl_ip_q;
		ctrl_port_d = ctrl_port_q;
		data_ip_d   = data_ip_q;
		data_port_d = data_port_q;
		rtt_d       = rtt_q;
		unique case (act)
			ACT_INV_NEW: begin
				phase_d     = PH_CTRL_INV;
				attempts_d  = attempts_q + 8'd1;
				last_send_d = now_inc;
			end
			ACT_INV_CTRL_RE,
			ACT_INV_DATA_RE,
			ACT_SYNC_TICK: last_send_d = now_inc;
			ACT_OK_CTRL: begin
				learned_d   = 1'b1;
				ctrl_ip_d   = item.src_ip;
				ctrl_port_d = item.src_port;
				data_ip_d   = item.src_ip;
				data_port_d = data_port_next;
				phase_d     = PH_DATA_INV;
			end
			ACT_OK_DATA: begin
				data_ip_d   = item.src_ip;
				data_port_d = item.src_port;
				phase_d     = PH_DATA_ACC;
				last_send_d = now_q;
			end
			ACT_NOBY: phase_d = PH_OFFLINE;
			ACT_CK1: begin
				rtt_d   = rtt_new;
				phase_d = PH_SYNCED;
			end
			ACT_STOP: phase_d = PH_STOPPED;
			default: begin
			end
		endcase
	end

	// Result items
	always_comb begin
		res0         = '0;
		res0.kind    = SK_NONE;
		res0.phase   = phase_d;
		res0.latency = rtt_d;
		res0.last    = 1'b1;
		res1         = '0;
		res1.kind    = SK_END;
		res1.via_data = 1'b1;
		res1.ip      = data_ip_q;
		res1.port    = data_port_q;
		res1.phase   = phase_d;
		res1.latency = rtt_d;
		res1.last    = 1'b1;
		two          = 1'b0;
		unique case (act)
			ACT_INV_NEW,
			ACT_INV_CTRL_RE: begin
				res0.kind = SK_INVITE;
				res0.ip   = cp_ip;
				res0.port = cp_port;
			end
			ACT_INV_DATA_RE: begin
				res0.kind     = SK_INVITE;
				res0.via_data = 1'b1;
				res0.ip       = data_ip_q;
				res0.port     = data_port_q;
			end
			ACT_SYNC_TICK: begin
				res0.kind     = SK_SYNC;
				res0.via_data = 1'b1;
				res0.ip       = data_ip_q;
				res0.port     = data_port_q;
				res0.count    = CK_COUNT_0;
				res0.ts1      = now_inc;
			end
			ACT_OK_CTRL: begin
				res0.kind     = SK_INVITE;
				res0.via_data = 1'b1;
				res0.ip       = item.src_ip;
				res0.port     = data_port_next;
			end
			ACT_OK_DATA: begin
				res0.kind     = SK_SYNC;
				res0.via_data = 1'b1;
				res0.ip       = item.src_ip;
				res0.port     = item.src_port;
				res0.count    = CK_COUNT_0;
				res0.ts1      = now_q;
			end
			ACT_CK0: begin
				res0.kind     = SK_SYNC;
				res0.via_data = item.on_data_port;
				res0.ip       = item.src_ip;
				res0.port     = item.src_port;
				res0.count    = CK_COUNT_1;
				res0.ts1      = item.sync_t1;
				res0.ts2      = now_q;
			end
			ACT_CK1: begin
				res0.kind     = SK_SYNC;
				res0.via_data = item.on_data_port;
				res0.ip       = item.src_ip;
				res0.port     = item.src_port;
				res0.count    = CK_COUNT_2;
				res0.ts1      = item.sync_t1;
				res0.ts2      = item.sync_t2;
				res0.ts3      = now_q;
			end
			ACT_STOP: begin
				res0.kind = SK_END;
				res0.ip   = cp_ip;
				res0.port = cp_port;
				res0.last = 1'b0;
				two       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Commit state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OFFLINE;
			attempts_q  <= 8'd0;
			now_q       <= 64'd0;
			last_send_q <= 64'd0;
			learned_q   <= 1'b0;
			ctrl_ip_q   <= 32'd0;
			ctrl_port_q <= 16'd0;
			data_ip_q   <= 32'd0;
			data_port_q <= 16'd0;
			rtt_q       <= 16'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			attempts_q  <= attempts_d;
			now_q       <= now_d;
			last_send_q <= last_send_d;
			learned_q   <= learned_d;
			ctrl_ip_q   <= ctrl_ip_d;
			ctrl_port_q <= ctrl_port_d;
			data_ip_q   <= data_ip_d;
			data_port_q <= data_port_d;
			rtt_q       <= rtt_d;
		end
	end

endmodule

// ----- hdl/rtp_midi_session_engine_unit.sv -----
// Timing: an item is registered in the input register on acceptance, and its first
// result is registered in the result register once the result stage is free; the
// second item of an end-session pair follows from the pending register unless stalled.
// Throughput: one item per cycle while the output is not stalled, except that a stop
// holds the result stage until both of its items are taken. Reset clears the session
// state, the valid flags and the configuration to its defaults.
module rtp_midi_session_engine_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [rmse_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [rmse_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// Input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      cmd,
	input  logic                            on_data_port,
	input  logic [31:0]                     src_ip,
	input  logic [15:0]                     src_port,
	input  logic [8:0]                      pkt_len,
	input  logic [15:0]                     magic,
	input  logic [15:0]                     cmd_word,
	input  logic [7:0]                      sync_count,
	input  logic [63:0]                     sync_t1,
	input  logic [63:0]                     sync_t2,
	// Output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      send_kind,
	output logic                            via_data_port,
	output logic [31:0]                     dest_ip,
	output logic [15:0]                     dest_port,
	output logic [1:0]                      sync_count_out,
	output logic [63:0]                     ts_first,
	output logic [63:0]                     ts_second,
	output logic [63:0]                     ts_third,
	output logic [2:0]                      session_state,
	output logic [15:0]                     round_trip,
	output logic                            last
);
	import rmse_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res0, res1;
	logic  two;
	res_t  out_q, pend_q;
	logic  out_valid_q, pend_valid_q;
	logic  out_free, fire, in_load;

	rmse_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.idx   (cfg_idx),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	rmse_core u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.cfg   (cfg),
		.res0  (res0),
		.res1  (res1),
		.two   (two)
	);

	// Handshake: the result stage takes a new item once any pair has drained and the shown result is taken
	assign out_free = !pend_valid_q && (!out_valid_q || !out_stall);
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_load  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_load) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_load) begin
			item_s1.cmd          <= cmd;
			item_s1.on_data_port <= on_data_port;
			item_s1.src_ip       <= src_ip;
			item_s1.src_port     <= src_port;
			item_s1.pkt_len      <= pkt_len;
			item_s1.magic        <= magic;
			item_s1.cmd_word     <= cmd_word;
			item_s1.sync_count   <= sync_count;
			item_s1.sync_t1      <= sync_t1;
			item_s1.sync_t2      <= sync_t2;
		end
	end

	// Result register and pending second item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= two;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q  <= res0;
			pend_q <= res1;
		end else if (out_valid_q && !out_stall && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign send_kind      = out_q.kind;
	assign via_data_port  = out_q.via_data;
	assign dest_ip        = out_q.ip;
	assign dest_port      = out_q.port;
	assign sync_count_out = out_q.count;
	assign ts_first       = out_q.ts1;
	assign ts_second      = out_q.ts2;
	assign ts_third       = out_q.ts3;
	assign session_state  = out_q.phase;
	assign round_trip     = out_q.latency;
	assign last           = out_q.last;

	// A pending second item always sits behind a shown one
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("pending item without a shown item");

	// No new item is committed while a pair is still draining
	a_no_fire_on_pend: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> !pend_valid_q)
		else $error("item committed over a pending item");

	// The second of a pair follows its first at once and closes the item
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && pend_valid_q) |=> (out_valid_q && out_q.last))
		else $error("second item of a pair lost");

	// A pair is opened only by an end-session item that is not final
	a_pair_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && two) |=> (out_q.kind == SK_END && !out_q.last && pend_valid_q))
		else $error("pair not started by an end-session item");

endmodule

// ----- test/rtp_midi_session_engine_unit_tb.sv -----
// Self-checking testbench for rtp_midi_session_engine_unit: a session predictor
// follows every accepted item and checks each outgoing message field by field.
// Depends on rmse_pkg (hdl/rmse_pkg.sv) and the block itself.

module rtp_midi_session_engine_unit_tb;
	import rmse_pkg::*;

	// Predicts the messages the session initiator sends and checks them in order
	class session_predictor;
		localparam int PRINT_LIMIT = 30;

		cfg_t        cfg;
		phase_t      ph;
		logic [7:0]  attempts;
		logic [63:0] now_ticks;
		logic [63:0] last_send;
		bit          ctrl_learned;
		logic [31:0] ctrl_ip_seen;
		logic [15:0] ctrl_port_seen;
		logic [31:0] data_ip;
		logic [15:0] data_port;
		logic [15:0] rtt;
		res_t        expected_sends[$];
		int          mismatches;
		int          results_seen;

		function new();
			cfg.peer_ip        = 32'd0;
			cfg.ctrl_port      = 16'd5004;
			cfg.retry_interval = 20'd15000;
			cfg.sync_interval  = 24'd100000;
			cfg.attempt_limit  = 8'd20;
			ph             = PH_OFFLINE;
			attempts       = 8'd0;
			now_ticks      = 64'd0;
			last_send      = 64'd0;
			ctrl_learned   = 1'b0;
			ctrl_ip_seen   = 32'd0;
			ctrl_port_seen = 16'd0;
			data_ip        = 32'd0;
			data_port      = 16'd0;
			rtt            = 16'd0;
			mismatches     = 0;
			results_seen   = 0;
		endfunction

		// Mirror a register write, masked to the register width
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
			CFG_PEER_IP:   cfg.peer_ip = val;
			CFG_CTRL_PORT: cfg.ctrl_port = val[15:0];
			CFG_RETRY_INT: cfg.retry_interval = val[19:0];
			CFG_SYNC_INT:  cfg.sync_interval = val[23:0];
			CFG_ATT_LIMIT: cfg.attempt_limit = val[7:0];
			default: ;
			endcase
		endfunction

		function logic [31:0] ctrl_dest_ip();
			return ctrl_learned ? ctrl_ip_seen : cfg.peer_ip;
		endfunction

		function logic [15:0] ctrl_dest_port();
			return ctrl_learned ? ctrl_port_seen : cfg.ctrl_port;
		endfunction

		function res_t message(kind_t k, logic via, logic [31:0] ip, logic [15:0] port,
				logic [1:0] count, logic [63:0] a, logic [63:0] b, logic [63:0] c);
			res_t r;
			r = '0;
			r.kind = k;
			r.via_data = via;
			r.ip = ip;
			r.port = port;
			r.count = count;
			r.ts1 = a;
			r.ts2 = b;
			r.ts3 = c;
			return r;
		endfunction

		// Advance the session by one accepted item and queue the messages it sends
		function void predict_sends(item_t it);
			res_t        msgs[2];
			int          n;
			logic [63:0] span;
			n = 0;
			case (it.cmd)
			CMD_TICK: begin
				now_ticks = now_ticks + 64'd1;
				if (ph == PH_OFFLINE) begin
					if (attempts < cfg.attempt_limit) begin
						msgs[0] = message(SK_INVITE, 1'b0, ctrl_dest_ip(), ctrl_dest_port(),
							CK_COUNT_0, 64'd0, 64'd0, 64'd0);
						ph = PH_CTRL_INV;
						attempts = attempts + 8'd1;
						last_send = now_ticks;
						n = 1;
					end
				end else if (ph == PH_CTRL_INV || ph == PH_DATA_INV) begin
					if (now_ticks - last_send > {44'd0, cfg.retry_interval}) begin
						if (ph == PH_CTRL_INV)
							msgs[0] = message(SK_INVITE, 1'b0, ctrl_dest_ip(),
								ctrl_dest_port(), CK_COUNT_0, 64'd0, 64'd0, 64'd0);
						else
							msgs[0] = message(SK_INVITE, 1'b1, data_ip, data_port,
								CK_COUNT_0, 64'd0, 64'd0, 64'd0);
						last_send = now_ticks;
						n = 1;
					end
				end else if (ph == PH_DATA_ACC || ph == PH_SYNCED) begin
					if (now_ticks - last_send > {40'd0, cfg.sync_interval}) begin
						msgs[0] = message(SK_SYNC, 1'b1, data_ip, data_port, CK_COUNT_0,
							now_ticks, 64'd0, 64'd0);
						last_send = now_ticks;
						n = 1;
					end
				end
			end
			CMD_PKT: begin
				if (ph != PH_STOPPED && it.pkt_len >= MIN_HDR_LEN
						&& it.magic == MAGIC_WORD) begin
					if (it.cmd_word == WORD_OK) begin
						if (!it.on_data_port) begin
							// learn the control peer and invite its data port
							ctrl_learned = 1'b1;
							ctrl_ip_seen = it.src_ip;
							ctrl_port_seen = it.src_port;
							data_ip = it.src_ip;
							data_port = cfg.ctrl_port + 16'd1;
							msgs[0] = message(SK_INVITE, 1'b1, data_ip, data_port,
								CK_COUNT_0, 64'd0, 64'd0, 64'd0);
							ph = PH_DATA_INV;
						end else begin
							data_ip = it.src_ip;
							data_port = it.src_port;
							ph = PH_DATA_ACC;
							msgs[0] = message(SK_SYNC, 1'b1, data_ip, data_port, CK_COUNT_0,
								now_ticks, 64'd0, 64'd0);
							last_send = now_ticks;
						end
						n = 1;
					end else if (it.cmd_word == WORD_NO || it.cmd_word == WORD_BY) begin
						ph = PH_OFFLINE;
					end else if (it.cmd_word == WORD_CK && it.pkt_len >= CK_LEN) begin
						if (it.sync_count == {6'd0, CK_COUNT_0}) begin
							msgs[0] = message(SK_SYNC, it.on_data_port, it.src_ip,
								it.src_port, CK_COUNT_1, it.sync_t1, now_ticks, 64'd0);
							n = 1;
						end else if (it.sync_count == {6'd0, CK_COUNT_1}) begin
							// round trip in ms, a timestamp from the future saturates
							span = (now_ticks - it.sync_t1) / 64'd10;
							rtt = (span > 64'd65535) ? RTT_MAX : span[15:0];
							msgs[0] = message(SK_SYNC, it.on_data_port, it.src_ip,
								it.src_port, CK_COUNT_2, it.sync_t1, it.sync_t2, now_ticks);
							ph = PH_SYNCED;
							n = 1;
						end
					end
				end
			end
			CMD_STOP: begin
				if (ph != PH_STOPPED) begin
					msgs[0] = message(SK_END, 1'b0, ctrl_dest_ip(), ctrl_dest_port(),
						CK_COUNT_0, 64'd0, 64'd0, 64'd0);
					msgs[1] = message(SK_END, 1'b1, data_ip, data_port,
						CK_COUNT_0, 64'd0, 64'd0, 64'd0);
					ph = PH_STOPPED;
					n = 2;
				end
			end
			default: ;
			endcase
			if (n == 0) begin
				msgs[0] = message(SK_NONE, 1'b0, 32'd0, 16'd0, CK_COUNT_0,
					64'd0, 64'd0, 64'd0);
				n = 1;
			end
			for (int k = 0; k < n; k++) begin
				msgs[k].phase = ph;
				msgs[k].latency = rtt;
				msgs[k].last = (k == n - 1);
				expected_sends.push_back(msgs[k]);
			end
		endfunction

		task flag(string what);
			if (mismatches < PRINT_LIMIT)
				$display("MISMATCH at result %0d: %s", results_seen, what);
			mismatches++;
		endtask

		task field_cmp(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				flag($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		// Compare one accepted result with the oldest pending message
		task check_send(res_t got);
			res_t want;
			results_seen++;
			if (expected_sends.size() == 0) begin
				flag("result with no item pending");
				return;
			end
			want = expected_sends.pop_front();
			field_cmp("send_kind", 64'(got.kind), 64'(want.kind));
			field_cmp("via_data_port", 64'(got.via_data), 64'(want.via_data));
			field_cmp("dest_ip", 64'(got.ip), 64'(want.ip));
			field_cmp("dest_port", 64'(got.port), 64'(want.port));
			field_cmp("sync_count_out", 64'(got.count), 64'(want.count));
			field_cmp("ts_first", got.ts1, want.ts1);
			field_cmp("ts_second", got.ts2, want.ts2);
			field_cmp("ts_third", got.ts3, want.ts3);
			field_cmp("session_state", 64'(got.phase), 64'(want.phase));
			field_cmp("round_trip", 64'(got.latency), 64'(want.latency));
			field_cmp("last", 64'(got.last), 64'(want.last));
		endtask
	endclass

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TIMEOUT_CYCLES = 200000;
	// Codes outside the defined sets
	localparam logic [1:0]           CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  out_stall = 1'b0;
	item_t                 cur = '0;

	logic        in_stall;
	logic        out_valid;
	logic [1:0]  send_kind;
	logic        via_data_port;
	logic [31:0] dest_ip;
	logic [15:0] dest_port;
	logic [1:0]  sync_count_out;
	logic [63:0] ts_first;
	logic [63:0] ts_second;
	logic [63:0] ts_third;
	logic [2:0]  session_state;
	logic [15:0] round_trip;
	logic        last;

	session_predictor predictor = new();

	int          idle_pct = 0;
	int          stall_pct = 0;
	int          hold_asked = 0;
	int          hold_taken = 0;
	int          hold_left = 0;
	int          items_sent = 0;
	int          settings = 0;
	logic [63:0] ticks_sent = 64'd0;

	rtp_midi_session_engine_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cur.cmd),
		.on_data_port   (cur.on_data_port),
		.src_ip         (cur.src_ip),
		.src_port       (cur.src_port),
		.pkt_len        (cur.pkt_len),
		.magic          (cur.magic),
		.cmd_word       (cur.cmd_word),
		.sync_count     (cur.sync_count),
		.sync_t1        (cur.sync_t1),
		.sync_t2        (cur.sync_t2),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send_kind      (send_kind),
		.via_data_port  (via_data_port),
		.dest_ip        (dest_ip),
		.dest_port      (dest_port),
		.sync_count_out (sync_count_out),
		.ts_first       (ts_first),
		.ts_second      (ts_second),
		.ts_third       (ts_third),
		.session_state  (session_state),
		.round_trip     (round_trip),
		.last           (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stall the output at random, or hold it off for a long stretch on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Check results first, then predict from the item taken at this edge
	always @(posedge clk) begin : watch
		res_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.kind = kind_t'(send_kind);
				got.via_data = via_data_port;
				got.ip = dest_ip;
				got.port = dest_port;
				got.count = sync_count_out;
				got.ts1 = ts_first;
				got.ts2 = ts_second;
				got.ts3 = ts_third;
				got.phase = phase_t'(session_state);
				got.latency = round_trip;
				got.last = last;
				predictor.check_send(got);
			end
			if (in_valid && !in_stall)
				predictor.predict_sends(cur);
		end
	end

	function automatic item_t pkt_item(input logic [15:0] word, input logic on_data,
			input logic [8:0] len, input logic [7:0] count, input logic [63:0] t1);
		item_t it;
		it.cmd = CMD_PKT;
		it.on_data_port = on_data;
		it.src_ip = $urandom;
		it.src_port = 16'($urandom);
		it.pkt_len = len;
		it.magic = MAGIC_WORD;
		it.cmd_word = word;
		it.sync_count = count;
		it.sync_t1 = t1;
		it.sync_t2 = {$urandom, $urandom};
		return it;
	endfunction

	// Mostly well-formed session traffic, some malformed or unknown packets
	function automatic item_t rand_item();
		item_t       it;
		int          pick;
		logic [63:0] back;
		logic [63:0] t1;
		logic [7:0]  count;
		pick = $urandom_range(99);
		case ($urandom_range(3))
		0: begin
			back = 64'($urandom_range(655370, 655340));
			t1 = ticks_sent - back;
		end
		1: begin
			back = 64'($urandom_range(20000));
			t1 = ticks_sent - back;
		end
		2: t1 = {$urandom, $urandom};
		default: begin
			back = 64'($urandom_range(100, 1));
			t1 = ticks_sent + back;
		end
		endcase
		count = 8'($urandom);
		if ($urandom_range(3) != 0)
			count = {7'd0, count[0]};
		it = pkt_item(WORD_CK, 1'($urandom_range(1)), 9'($urandom_range(256, 36)),
			count, t1);
		if (pick < 40) begin
			it.cmd = CMD_TICK;
		end else if (pick < 58) begin
			it.cmd_word = WORD_OK;
			it.pkt_len = 9'($urandom_range(256, 4));
		end else if (pick >= 80 && pick < 85) begin
			it.cmd_word = pick[0] ? WORD_NO : WORD_BY;
			it.pkt_len = 9'($urandom_range(256, 4));
		end else if (pick >= 85) begin
			case ($urandom_range(3))
			0: it.magic = 16'($urandom);
			1: it.pkt_len = 9'($urandom_range(3));
			2: it.cmd_word = 16'($urandom);
			default: it.pkt_len = 9'($urandom_range(35, 4));
			endcase
		end
		return it;
	endfunction

	function automatic item_t tick_item();
		item_t it;
		it = rand_item();
		it.cmd = CMD_TICK;
		return it;
	endfunction

	// Offer one item after a random gap and hold it until taken
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		cur <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (it.cmd == CMD_TICK)
			ticks_sent = ticks_sent + 64'd1;
	endtask

	// Stop offering and wait for every pending result, then let the block settle
	task automatic wait_drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (predictor.expected_sends.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		predictor.set_reg(idx, val);
	endtask

	task automatic configure(input logic [31:0] ip, input logic [15:0] port,
			input logic [19:0] retry_gap, input logic [23:0] sync_gap,
			input logic [7:0] limit);
		cfg_write(CFG_PEER_IP, ip);
		cfg_write(CFG_CTRL_PORT, {16'd0, port});
		cfg_write(CFG_RETRY_INT, {12'd0, retry_gap});
		cfg_write(CFG_SYNC_INT, {8'd0, sync_gap});
		cfg_write(CFG_ATT_LIMIT, {24'd0, limit});
		settings++;
	endtask

	task automatic random_run(input int count, input int idle, input int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count) send_item(rand_item());
		wait_drain();
	endtask

	initial begin : stimulus
		item_t it;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short intervals so retries and periodic syncs show up quickly
		configure(32'hFFFF_FFFF, 16'd65534, 20'd1, 24'd1, 8'd255);
		// Upper bits are dropped; an unused index changes nothing
		cfg_write(CFG_CTRL_PORT, {16'hBEEF, 16'd65534});
		cfg_write(CFG_UNUSED, $urandom);

		// Directed: unknown command, invitation and its resend
		it = rand_item();
		it.cmd = CMD_UNUSED;
		send_item(it);
		repeat (3) send_item(tick_item());
		// Malformed packets: short header, bad magic, unknown word
		send_item(pkt_item(WORD_OK, 1'b0, 9'd3, 8'd0, 64'd0));
		it = pkt_item(WORD_OK, 1'b0, 9'd4, 8'd0, 64'd0);
		it.magic = 16'h0000;
		send_item(it);
		send_item(pkt_item(16'h0000, 1'b0, 9'd256, 8'd0, 64'd0));
		// Control acceptance from an all-ones address; the data port is the configured port plus one
		it = pkt_item(WORD_OK, 1'b0, MIN_HDR_LEN, 8'd0, 64'd0);
		it.src_ip = 32'hFFFF_FFFF;
		it.src_port = 16'hFFFF;
		send_item(it);
		repeat (3) send_item(tick_item());
		it = pkt_item(WORD_OK, 1'b1, 9'd256, 8'd0, 64'd0);
		it.src_ip = 32'd0;
		it.src_port = 16'd0;
		send_item(it);
		repeat (2) send_item(tick_item());
		// Clock sync: too short, first reply, latency either side of saturation
		send_item(pkt_item(WORD_CK, 1'b1, 9'd35, 8'd0, 64'd0));
		send_item(pkt_item(WORD_CK, 1'b0, CK_LEN, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF));
		send_item(pkt_item(WORD_CK, 1'b1, CK_LEN, 8'd1, ticks_sent - 64'd655359));
		send_item(pkt_item(WORD_CK, 1'b1, CK_LEN, 8'd1, ticks_sent - 64'd655349));
		send_item(pkt_item(WORD_CK, 1'b0, CK_LEN, 8'd1, ticks_sent + 64'd5));
		send_item(pkt_item(WORD_CK, 1'b1, 9'd256, 8'd1, ticks_sent));
		send_item(pkt_item(WORD_CK, 1'b1, CK_LEN, 8'd2, 64'd0));
		send_item(pkt_item(WORD_CK, 1'b0, CK_LEN, 8'hFF, 64'd0));
		// Refusal and goodbye drop back to offline; the next tick re-invites
		send_item(pkt_item(WORD_NO, 1'b0, MIN_HDR_LEN, 8'd0, 64'd0));
		send_item(tick_item());
		send_item(pkt_item(WORD_BY, 1'b1, MIN_HDR_LEN, 8'd0, 64'd0));

		// Random phases over several register settings
		random_run(50, 0, 0);
		random_run(50, 0, 0);
		configure(32'd0, 16'd0, 20'd5, 24'd7, 8'd3);
		random_run(100, 61, 0);
		configure($urandom, 16'd5004, 20'd3, 24'd4, 8'd0);
		random_run(100, 0, 61);
		configure($urandom, 16'($urandom_range(65534)), 20'd1000000, 24'd10000000, 8'd20);
		random_run(100, 12, 12);

		// Hold the output off while items keep coming so the block backs up
		configure(32'h0A00_0001, 16'd5004, 20'd2, 24'd2, 8'd255);
		idle_pct = 0;
		stall_pct = 0;
		hold_asked++;
		repeat (40) send_item(rand_item());
		wait_drain();

		// Stop, then show that the stopped session ignores everything
		idle_pct = 12;
		stall_pct = 12;
		it = rand_item();
		it.cmd = CMD_STOP;
		send_item(it);
		send_item(it);
		send_item(pkt_item(WORD_OK, 1'b0, 9'd256, 8'd0, 64'd0));
		send_item(tick_item());
		send_item(pkt_item(WORD_CK, 1'b1, CK_LEN, 8'd1, ticks_sent));
		send_item(tick_item());
		wait_drain();

		if (predictor.expected_sends.size() != 0)
			predictor.flag($sformatf("%0d expected results never arrived",
				predictor.expected_sends.size()));
		$display("Run covered %0d items and %0d results under %0d register settings,",
			items_sent, predictor.results_seen, settings);
		$display("with idle and stall mixes, a long output hold-off and a final stop.");
		if (predictor.mismatches == 0)
			$display("rtp_midi_session_engine_unit test passed");
		else
			$display("rtp_midi_session_engine_unit test failed");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("rtp_midi_session_engine_unit test failed");
		$finish;
	end

endmodule
